// ===== design/geq_pkg.sv =====
package geq_pkg;

    localparam int unsigned N_EVENTS = 12;

    localparam logic [15:0] CENTRE_OFFSET = 16'd32768;
    localparam logic [9:0]  TRIG_FULL     = 10'd1023;
    localparam logic [4:0]  INT_MIN_OUT   = 5'd5;
    localparam logic [4:0]  INT_SPAN      = 5'd25;

    localparam logic [15:0] RST_NAV_HOLD  = 16'd200;
    localparam logic [14:0] RST_STICK_TH  = 15'd16000;
    localparam logic [15:0] RST_TRIG_HOLD = 16'd100;
    localparam logic [9:0]  RST_TRIG_TH   = 10'd100;

    typedef enum logic [1:0] {
        REG_NAV_HOLD  = 2'd0,
        REG_STICK_TH  = 2'd1,
        REG_TRIG_HOLD = 2'd2,
        REG_TRIG_TH   = 2'd3
    } t_reg_idx;

    typedef enum logic [1:0] {
        HAP_NONE  = 2'd0,
        HAP_PULSE = 2'd1,
        HAP_TICK  = 2'd2
    } t_haptic;

    typedef enum logic [3:0] {
        EV_A         = 4'd0,
        EV_B         = 4'd1,
        EV_Y         = 4'd2,
        EV_MENU      = 4'd3,
        EV_BUMP_L    = 4'd4,
        EV_BUMP_R    = 4'd5,
        EV_NAV_LEFT  = 4'd6,
        EV_NAV_RIGHT = 4'd7,
        EV_NAV_UP    = 4'd8,
        EV_NAV_DOWN  = 4'd9,
        EV_TRIG_R    = 4'd10,
        EV_TRIG_L    = 4'd11
    } t_event;

    typedef struct packed {
        logic        connected;
        logic [6:0]  buttons;
        logic [3:0]  dpad;
        logic [15:0] stick_x;
        logic [15:0] stick_y;
        logic [9:0]  trig_left;
        logic [9:0]  trig_right;
        logic [31:0] now_ms;
    } t_in_item;

    typedef struct packed {
        logic [3:0] event_code;
        logic [4:0] intensity;
        logic [1:0] haptic;
        logic       last;
    } t_out_item;

    typedef struct packed {
        logic [15:0] nav_hold_ms;
        logic [14:0] stick_threshold;
        logic [15:0] trigger_hold_ms;
        logic [9:0]  trig_th;
    } t_cfg;

    typedef struct packed {
        logic       load;
        logic       eval;
        logic       div_en;
        logic       div_sel;
        logic [2:0] div_k;
        logic       emit;
    } t_cmd;

    typedef struct packed {
        logic mask_r;
        logic mask_l;
        logic mask_empty;
    } t_sts;

endpackage

// ===== design/geq_ctrl.sv =====
module geq_ctrl
    import geq_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_stall,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_EVAL = 5'b00010,
        S_DIVR = 5'b00100,
        S_DIVL = 5'b01000,
        S_EMIT = 5'b10000
    } t_state;

    localparam logic [2:0] K_TOP = 3'd4;

    t_state     r_state, n_state;
    logic [2:0] r_k, n_k;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_k     <= K_TOP;
        end else begin
            r_state <= n_state;
            r_k     <= n_k;
        end
    end

    always_comb begin
        n_state = r_state;
        n_k     = r_k;
        o_cmd   = '0;
        o_cmd.div_k = r_k;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_EVAL;
                end
            end
            S_EVAL: begin
                o_cmd.eval = 1'b1;
                n_state    = S_DIVR;
                n_k        = K_TOP;
            end
            S_DIVR: begin
                if (!i_sts.mask_r || r_k == 3'd0) begin
                    n_state = S_DIVL;
                    n_k     = K_TOP;
                end else begin
                    n_k = r_k - 3'd1;
                end
                o_cmd.div_en  = i_sts.mask_r;
                o_cmd.div_sel = 1'b0;
            end
            S_DIVL: begin
                if (!i_sts.mask_l || r_k == 3'd0) begin
                    n_state = S_EMIT;
                    n_k     = K_TOP;
                end else begin
                    n_k = r_k - 3'd1;
                end
                o_cmd.div_en  = i_sts.mask_l;
                o_cmd.div_sel = 1'b1;
            end
            S_EMIT: begin
                o_cmd.emit = 1'b1;
                if (i_sts.mask_empty) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
                n_k     = K_TOP;
            end
        endcase
    end

    assign o_in_stall = (r_state != S_IDLE);

endmodule

// ===== design/geq_dp.sv =====
module geq_dp
    import geq_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_in_item  i_in_item,
    input  t_cfg      i_cfg,
    input  t_cmd      i_cmd,
    output t_sts      o_sts,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_item o_out_item
);

    function automatic logic [3:0] f_dirs(input logic [15:0] ax, input logic [15:0] ay,
                                          input logic [3:0] dp, input logic [14:0] th);
        logic signed [16:0] x;
        logic signed [16:0] y;
        logic signed [16:0] p;
        logic signed [16:0] m;
        logic [3:0]         d;
        begin
            x = {ax[15], ax};
            y = {ay[15], ay};
            p = {2'b00, th};
            m = -p;
            d = dp;
            if (x < m) d[0] = 1'b1;
            if (x > p) d[1] = 1'b1;
            if (y < m) d[2] = 1'b1;
            if (y > p) d[3] = 1'b1;
            f_dirs = d;
        end
    endfunction

    t_in_item              r_item;
    logic [6:0]            r_prev_buttons;
    logic [3:0]            r_prev_dpad;
    logic [15:0]           r_prev_ax, r_prev_ay;
    logic [31:0]           r_nav_time, r_trig_time;
    logic [N_EVENTS-1:0]   r_mask;
    logic [14:0]           r_rem_r, r_rem_l;
    logic [9:0]            r_den;
    logic [4:0]            r_q_r, r_q_l;
    logic                  r_out_valid;
    t_out_item             r_out;

    logic [6:0]          btn_rise;
    logic [31:0]         nav_dt, trig_dt;
    logic                nav_ok, trig_ok;
    logic [15:0]         ax, ay;
    logic [3:0]          dir_cur, dir_was, dir_rise;
    logic                hit_r, hit_l;
    logic [N_EVENTS-1:0] mask_new;
    logic [9:0]          diff_r, diff_l;
    logic [14:0]         num_r, num_l;
    logic [14:0]         rem_sel, div_sh;
    logic                div_ge;
    logic                out_take, emit_go;
    logic [3:0]          sel_idx;
    logic [N_EVENTS-1:0] mask_rest;
    t_out_item           n_out;

    always_comb begin
        btn_rise = r_item.buttons & ~r_prev_buttons;
        nav_dt   = r_item.now_ms - r_nav_time;
        trig_dt  = r_item.now_ms - r_trig_time;
        nav_ok   = nav_dt >= {16'd0, i_cfg.nav_hold_ms};
        trig_ok  = trig_dt >= {16'd0, i_cfg.trigger_hold_ms};
        ax       = r_item.stick_x - CENTRE_OFFSET;
        ay       = r_item.stick_y - CENTRE_OFFSET;
        dir_cur  = f_dirs(ax, ay, r_item.dpad, i_cfg.stick_threshold);
        dir_was  = f_dirs(r_prev_ax, r_prev_ay, r_prev_dpad, i_cfg.stick_threshold);
        dir_rise = nav_ok ? (dir_cur & ~dir_was) : 4'd0;
        hit_r    = trig_ok && (r_item.trig_right > i_cfg.trig_th);
        hit_l    = trig_ok && (r_item.trig_left > i_cfg.trig_th);
        mask_new = {hit_l, hit_r, dir_rise,
                    btn_rise[6], btn_rise[5], btn_rise[4], btn_rise[3],
                    btn_rise[1], btn_rise[0]};
        diff_r   = r_item.trig_right - i_cfg.trig_th;
        diff_l   = r_item.trig_left - i_cfg.trig_th;
        num_r    = 15'(diff_r) * 15'(INT_SPAN);
        num_l    = 15'(diff_l) * 15'(INT_SPAN);
    end

    // shared restoring divide step, one quotient bit per cycle
    always_comb begin
        rem_sel = i_cmd.div_sel ? r_rem_l : r_rem_r;
        div_sh  = 15'(r_den) << i_cmd.div_k;
        div_ge  = rem_sel >= div_sh;
    end

    always_comb begin
        sel_idx = 4'd0;
        for (int i = N_EVENTS - 1; i >= 0; i--) begin
            if (r_mask[i]) sel_idx = 4'(i);
        end
        mask_rest        = r_mask & (r_mask - 1'b1);
        n_out.event_code = sel_idx;
        n_out.last       = (mask_rest == '0);
        case (sel_idx)
            EV_A, EV_B, EV_Y, EV_MENU, EV_BUMP_L, EV_BUMP_R: begin
                n_out.intensity = 5'd0;
                n_out.haptic    = HAP_PULSE;
            end
            EV_NAV_LEFT, EV_NAV_RIGHT, EV_NAV_UP, EV_NAV_DOWN: begin
                n_out.intensity = 5'd0;
                n_out.haptic    = HAP_TICK;
            end
            EV_TRIG_R: begin
                n_out.intensity = r_q_r + INT_MIN_OUT;
                n_out.haptic    = HAP_NONE;
            end
            EV_TRIG_L: begin
                n_out.intensity = r_q_l + INT_MIN_OUT;
                n_out.haptic    = HAP_NONE;
            end
            default: begin
                n_out.intensity = 5'd0;
                n_out.haptic    = HAP_NONE;
            end
        endcase
        out_take = r_out_valid && !i_out_stall;
        emit_go  = i_cmd.emit && (r_mask != '0) && (!r_out_valid || !i_out_stall);
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_item <= i_in_item;
        end
        if (i_cmd.eval) begin
            r_rem_r <= num_r;
            r_rem_l <= num_l;
            r_den   <= TRIG_FULL - i_cfg.trig_th;
        end else if (i_cmd.div_en && div_ge) begin
            if (i_cmd.div_sel) begin
                r_rem_l <= r_rem_l - div_sh;
            end else begin
                r_rem_r <= r_rem_r - div_sh;
            end
        end
        if (emit_go) begin
            r_out <= n_out;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_buttons <= '0;
            r_prev_dpad    <= '0;
            r_prev_ax      <= '0;
            r_prev_ay      <= '0;
            r_nav_time     <= '0;
            r_trig_time    <= '0;
            r_mask         <= '0;
            r_q_r          <= '0;
            r_q_l          <= '0;
            r_out_valid    <= 1'b0;
        end else begin
            if (i_cmd.eval) begin
                r_q_r <= '0;
                r_q_l <= '0;
                if (r_item.connected) begin
                    r_mask         <= mask_new;
                    r_prev_buttons <= r_item.buttons;
                    if (nav_ok) begin
                        r_prev_ax   <= ax;
                        r_prev_ay   <= ay;
                        r_prev_dpad <= r_item.dpad;
                        if (dir_rise != 4'd0) begin
                            r_nav_time <= r_item.now_ms;
                        end
                    end
                    if (hit_r || hit_l) begin
                        r_trig_time <= r_item.now_ms;
                    end
                end else begin
                    r_mask <= '0;
                end
            end else if (i_cmd.div_en && div_ge) begin
                if (i_cmd.div_sel) begin
                    r_q_l <= r_q_l | (5'd1 << i_cmd.div_k);
                end else begin
                    r_q_r <= r_q_r | (5'd1 << i_cmd.div_k);
                end
            end else if (emit_go) begin
                r_mask <= mask_rest;
            end
            if (emit_go) begin
                r_out_valid <= 1'b1;
            end else if (out_take) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_sts.mask_r     = r_mask[EV_TRIG_R];
    assign o_sts.mask_l     = r_mask[EV_TRIG_L];
    assign o_sts.mask_empty = (r_mask == '0);
    assign o_out_valid      = r_out_valid;
    assign o_out_item       = r_out;

endmodule

// ===== design/gamepad_event_qualifier_unit.sv =====
// Gamepad event qualifier: one controller sample in, zero to twelve event beats out.
// Input channel: i_in_valid / o_in_stall with the sample in i_in_item; a beat is taken
// when valid is high and stall is low. Output channel: o_out_valid / i_out_stall with
// one event in o_out_item; the final event of a sample carries last.
// Sequence: a sample is registered when taken and evaluated in the next cycle. Each
// trigger that fires then passes through a shared one-bit-per-cycle divider, right
// trigger first, and events leave one per cycle from an output register while the
// receiver does not stall. A disconnected sample still passes through the divide and
// emit states but produces no events.
// The next sample is taken once the previous sample's events are all in or past the
// output register, so a stalled receiver holds the last event there while the
// following sample is already accepted; further stall holds the block in event output.
// Configuration is over the APB port at byte addresses 0, 4, 8, 12; the user writes it only
// while the block is idle, which it does not enforce. Synchronous reset loads the register
// defaults, clears the edge history and hold time stamps, and empties the output register.
module gamepad_event_qualifier_unit
    import geq_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  t_in_item    i_in_item,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output t_out_item   o_out_item,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    t_cfg     r_cfg;
    t_cmd     cmd;
    t_sts     sts;
    t_reg_idx reg_idx;
    logic     cfg_wr;

    assign reg_idx = t_reg_idx'(paddr[3:2]);
    assign cfg_wr  = psel && penable && pwrite;
    assign pready  = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.nav_hold_ms     <= RST_NAV_HOLD;
            r_cfg.stick_threshold <= RST_STICK_TH;
            r_cfg.trigger_hold_ms <= RST_TRIG_HOLD;
            r_cfg.trig_th         <= RST_TRIG_TH;
        end else if (cfg_wr) begin
            case (reg_idx)
                REG_NAV_HOLD:  r_cfg.nav_hold_ms     <= pwdata[15:0];
                REG_STICK_TH:  r_cfg.stick_threshold <= pwdata[14:0];
                REG_TRIG_HOLD: r_cfg.trigger_hold_ms <= pwdata[15:0];
                REG_TRIG_TH:   r_cfg.trig_th         <= pwdata[9:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            REG_NAV_HOLD:  prdata = {16'd0, r_cfg.nav_hold_ms};
            REG_STICK_TH:  prdata = {17'd0, r_cfg.stick_threshold};
            REG_TRIG_HOLD: prdata = {16'd0, r_cfg.trigger_hold_ms};
            REG_TRIG_TH:   prdata = {22'd0, r_cfg.trig_th};
            default:       prdata = 32'd0;
        endcase
    end

    geq_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    geq_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_item   (i_in_item),
        .i_cfg       (r_cfg),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_item  (o_out_item)
    );

endmodule
